[design/gjdc_pkg.sv]
// Shared widths, calendar constants and reciprocal multipliers for the date/day-number converter.
package gjdc_pkg;

    localparam int VALUE_W = 28;
    localparam int TODAY_W = 23;
    localparam int DATA_W  = 32;
    localparam int NUM_STAGES = 11;

    localparam logic [TODAY_W-1:0] TODAY_RESET = 23'd2451545;

    // Calendar constants
    localparam logic [30:0] JDN_SHIFT   = 31'd6884477;
    localparam logic [27:0] JDN_EPOCH   = 28'd1721119;
    localparam logic [13:0] CENTURY_FIX = 14'd1900;

    localparam logic [63:0] DIV_100  = 64'd100;
    localparam logic [63:0] DIV_5    = 64'd5;
    localparam logic [63:0] DIV_400Y = 64'd146097;
    localparam logic [63:0] DIV_4Y   = 64'd1461;
    localparam logic [63:0] DIV_MON  = 64'd153;

    // Reciprocal multipliers: floor(x * MAGIC / 2^SH) == floor(x / D) holds
    // while x * (MAGIC * D - 2^SH) < 2^SH, which SH = x width + ceil(log2 D) covers.
    localparam int P100_SH = 34;   // packed date, x < 2^27
    localparam logic [27:0] P100_MAGIC =
        28'(((64'd1 << P100_SH) + DIV_100 - 64'd1) / DIV_100);

    localparam int Q100_SH = 28;   // yyyymm, x < 2^21
    localparam logic [21:0] Q100_MAGIC =
        22'(((64'd1 << Q100_SH) + DIV_100 - 64'd1) / DIV_100);

    localparam int Y100_SH = 21;   // year, x < 2^14
    localparam logic [14:0] Y100_MAGIC =
        15'(((64'd1 << Y100_SH) + DIV_100 - 64'd1) / DIV_100);

    localparam int D5A_SH = 17;    // month term, x < 2^14
    localparam logic [14:0] D5A_MAGIC =
        15'(((64'd1 << D5A_SH) + DIV_5 - 64'd1) / DIV_5);

    localparam int D400Y_SH = 48;  // shifted day number, x < 2^30
    localparam logic [30:0] D400Y_MAGIC =
        31'(((64'd1 << D400Y_SH) + DIV_400Y - 64'd1) / DIV_400Y);

    localparam int D4Y_SH = 29;    // day within era, x < 2^18
    localparam logic [18:0] D4Y_MAGIC =
        19'(((64'd1 << D4Y_SH) + DIV_4Y - 64'd1) / DIV_4Y);

    localparam int DMON_SH = 19;   // day within year, x < 2^11
    localparam logic [11:0] DMON_MAGIC =
        12'(((64'd1 << DMON_SH) + DIV_MON - 64'd1) / DIV_MON);

    localparam int D5B_SH = 11;    // day within month, x < 2^8
    localparam logic [8:0] D5B_MAGIC =
        9'(((64'd1 << D5B_SH) + DIV_5 - 64'd1) / DIV_5);

endpackage

[design/gregorian_julian_day_conversion_core.sv]
// Top level: pipelined Gregorian yyyymmdd <-> Julian day number converter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready  | s_tuser = mode, s_tdata[27:0] = value
//  m_*     | out       | m_tvalid / m_tready  | m_tdata[27:0] = converted
//  cfg_*   | in        | cfg_valid / cfg_ready| cfg_data = today_day_number (23 bits)
//
//  One transaction per cycle sustained while m_tready stays high. A result
//  passes the input register, stages 1 to 10 and the output register in order; each of the 11 stages holds
//  at most one constant-divisor reciprocal multiply per direction.
//  Reset clears every stage valid bit and loads today_day_number with 2451545.
//  Stalls: a stage holds while the one after it is full and not moving; empty
//  stages keep filling, so input is taken while a finished result waits.
//
//  Both directions are computed side by side for every transaction; the mode
//  bit travels with the transaction and picks the result at the last stage.
//  All signed divisions are done on magnitudes and the sign is put back,
//  which matches truncation toward zero.
module gregorian_julian_day_conversion_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gjdc_pkg::TODAY_W-1:0]  cfg_data,   // [22:0] today_day_number
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gjdc_pkg::DATA_W-1:0]   s_tdata,    // [27:0] value, [31:28] zero
    input  logic                          s_tuser,    // [0] mode
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gjdc_pkg::DATA_W-1:0]   m_tdata     // [27:0] converted, [31:28] zero
);
    import gjdc_pkg::*;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  out_valid_reg;
    logic [NUM_STAGES:0]   stage_ready;
    logic [TODAY_W-1:0]    today_reg;
    logic                  in_acc;
    logic                  out_acc;

    // ------------------------------------------------------------------
    // Stage payload
    // ------------------------------------------------------------------
    logic                 mode_reg [0:10];
    logic [VALUE_W-1:0]   value_reg;

    // date -> day number
    logic                 rel_reg  [1:6];
    logic [27:0]          rsum_reg [1:6];
    logic [26:0]          pack_reg;
    logic [20:0]          q1_reg   [1:2];
    logic [6:0]           day_reg  [2:6];
    logic [13:0]          yq_reg;
    logic [6:0]           mshift_reg;
    logic [13:0]          yshift_reg [3:4];
    logic [7:0]           cen_reg;
    logic [13:0]          m153_reg;
    logic [6:0]           ry_reg;
    logic [22:0]          t1_reg [5:6];
    logic [11:0]          t3_reg [5:6];
    logic [15:0]          t2_reg;
    logic [27:0]          res_reg [7:10];

    // day number -> date
    logic                 neg_reg  [1:4];
    logic [29:0]          abs_reg  [1:2];
    logic [11:0]          qa_reg   [2:4];
    logic [16:0]          dd_reg;
    logic                 neg2_reg [4:5];
    logic [17:0]          abs2_reg [4:5];
    logic [6:0]           qb_reg;
    logic [19:0]          yrc_reg;
    logic [19:0]          yr_reg [6:9];
    logic [9:0]           dd2_reg;
    logic                 neg3_reg [7:9];
    logic [10:0]          abs3_reg [7:8];
    logic [3:0]           qc_reg;
    logic [7:0]           rc_reg;
    logic [4:0]           month_reg;
    logic [6:0]           dd3_reg;
    logic [27:0]          ypart_reg;
    logic [27:0]          out_data_reg;

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    logic [27:0] rsum_next;
    logic        rel_next;
    logic [54:0] q1_prod;
    logic [30:0] t_full;
    logic [29:0] abs_next;

    logic [42:0] yq_prod;
    logic [26:0] day_full;
    logic [60:0] qa_prod;

    logic [20:0] month_full;
    logic [6:0]  month0;
    logic [13:0] year_adj;
    logic [6:0]  mshift_next;
    logic [13:0] yshift_next;
    logic [29:0] rem400;
    logic [16:0] dd_next;

    logic [28:0] cen_prod;
    logic [13:0] m153_next;
    logic [18:0] t2s;
    logic [17:0] abs2_next;

    logic [13:0] ry_full;
    logic [25:0] t1_prod;
    logic [28:0] t3_prod;
    logic [36:0] qb_prod;
    logic [19:0] yrc_mag;
    logic [19:0] yrc_next;

    logic [17:0] t2_prod;
    logic [17:0] rem4y;
    logic [9:0]  q4;
    logic [9:0]  dd2_next;
    logic [19:0] yr6_next;

    logic [27:0] sum_next;
    logic [27:0] res_next;
    logic [11:0] dd2x;
    logic [11:0] t3s;
    logic [10:0] abs3_next;

    logic [22:0] qc_prod;

    logic [10:0] rc_full;
    logic [4:0]  mm;
    logic        late;
    logic [4:0]  month_next;
    logic [19:0] yr9_next;

    logic [16:0] d5_prod;
    logic [6:0]  d5;
    logic [6:0]  dd3_next;
    logic [27:0] ypart_next;
    logic [27:0] conv_next;

    // ------------------------------------------------------------------
    // Handshake: a stage may load when it is empty or its content moves on
    // ------------------------------------------------------------------
    always_comb
    begin
        stage_ready[NUM_STAGES] = !out_valid_reg || m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_tready  = stage_ready[0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(DATA_W-VALUE_W){1'b0}}, out_data_reg};
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && stage_ready[0];
    assign out_acc   = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            today_reg     <= TODAY_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                today_reg <= cfg_data;
            end
            if (stage_ready[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (stage_ready[NUM_STAGES])
            begin
                out_valid_reg <= valid_reg[NUM_STAGES-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: relative sum, first /100 of the packed date, 4*jdn - shift
    // ------------------------------------------------------------------
    always_comb
    begin
        rsum_next = 28'(today_reg) + value_reg;
        rel_next  = value_reg[VALUE_W-1] || (value_reg == '0);
        q1_prod   = 55'(value_reg[26:0]) * 55'(P100_MAGIC);
        t_full    = {value_reg[VALUE_W-1], value_reg, 2'b00} - JDN_SHIFT;
        abs_next  = t_full[30] ? 30'(31'd0 - t_full) : t_full[29:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: day digits, year = yyyymm / 100, era = |t| / 146097
    // ------------------------------------------------------------------
    always_comb
    begin
        day_full = pack_reg - 27'(q1_reg[1]) * 27'(DIV_100);
        yq_prod  = 43'(q1_reg[1]) * 43'(Q100_MAGIC);
        qa_prod  = 61'(abs_reg[1]) * 61'(D400Y_MAGIC);
    end

    // ------------------------------------------------------------------
    // Stage 3: month digits, two-digit years, March-based shift;
    //          day within era
    // ------------------------------------------------------------------
    always_comb
    begin
        month_full = q1_reg[2] - 21'(yq_reg) * 21'(DIV_100);
        month0     = month_full[6:0];
        year_adj   = (yq_reg < 14'(DIV_100)) ? yq_reg + CENTURY_FIX : yq_reg;
        if (month0 > 7'd2)
        begin
            mshift_next = month0 - 7'd3;
            yshift_next = year_adj;
        end
        else
        begin
            mshift_next = month0 + 7'd9;
            yshift_next = year_adj - 14'd1;
        end
        rem400  = abs_reg[2] - 30'(qa_reg[2]) * 30'(DIV_400Y);
        dd_next = neg_reg[2] ? 17'd0 - 17'(rem400[17:2]) : 17'(rem400[17:2]);
    end

    // ------------------------------------------------------------------
    // Stage 4: century = yshift / 100, 153*m + 2; 4*dd + 3
    // ------------------------------------------------------------------
    always_comb
    begin
        cen_prod  = 29'(yshift_reg[3]) * 29'(Y100_MAGIC);
        m153_next = 14'(mshift_reg) * 14'(DIV_MON) + 14'd2;
        t2s       = {dd_reg, 2'b11};
        abs2_next = dd_reg[16] ? 18'(19'd0 - t2s) : t2s[17:0];
    end

    // ------------------------------------------------------------------
    // Stage 5: year in century, century days, month days;
    //          years within era, signed era years
    // ------------------------------------------------------------------
    always_comb
    begin
        ry_full  = yshift_reg[4] - 14'(cen_reg) * 14'(DIV_100);
        t1_prod  = 26'(cen_reg) * 26'(DIV_400Y);
        t3_prod  = 29'(m153_reg) * 29'(D5A_MAGIC);
        qb_prod  = 37'(abs2_reg[4]) * 37'(D4Y_MAGIC);
        yrc_mag  = 20'(qa_reg[4]) * 20'(DIV_100);
        yrc_next = neg_reg[4] ? 20'd0 - yrc_mag : yrc_mag;
    end

    // ------------------------------------------------------------------
    // Stage 6: year days; day of year, year total
    // ------------------------------------------------------------------
    always_comb
    begin
        t2_prod  = 18'(ry_reg) * 18'(DIV_4Y);
        rem4y    = abs2_reg[5] - 18'(qb_reg) * 18'(DIV_4Y);
        q4       = {1'b0, rem4y[10:2]};
        dd2_next = (neg2_reg[5] ? 10'd0 - q4 : q4) + 10'd1;
        yr6_next = yrc_reg + (neg2_reg[5] ? 20'd0 - 20'(qb_reg) : 20'(qb_reg));
    end

    // ------------------------------------------------------------------
    // Stage 7: day number sum or relative sum; 5*d - 3
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_next  = 28'(t1_reg[6]) + 28'(t2_reg) + 28'(t3_reg[6]) + 28'(day_reg[6])
                  + JDN_EPOCH;
        res_next  = rel_reg[6] ? rsum_reg[6] : sum_next;
        dd2x      = {{2{dd2_reg[9]}}, dd2_reg};
        t3s       = (dd2x << 2) + dd2x - 12'd3;
        abs3_next = t3s[11] ? 11'(12'd0 - t3s) : t3s[10:0];
    end

    // ------------------------------------------------------------------
    // Stage 8: month index magnitude = |t| / 153
    // ------------------------------------------------------------------
    assign qc_prod = 23'(abs3_reg[7]) * 23'(DMON_MAGIC);

    // ------------------------------------------------------------------
    // Stage 9: remainder, March-based month back to January-based
    // ------------------------------------------------------------------
    always_comb
    begin
        rc_full    = abs3_reg[8] - 11'(qc_reg) * 11'(DIV_MON);
        mm         = (neg3_reg[8] ? 5'd0 - 5'(qc_reg) : 5'(qc_reg)) + 5'd1;
        late       = $signed(mm) >= 5'sd11;
        month_next = late ? mm - 5'd10 : mm + 5'd2;
        yr9_next   = yr_reg[8] + 20'(late);
    end

    // ------------------------------------------------------------------
    // Stage 10: day of month, yyyymm00 part
    // ------------------------------------------------------------------
    always_comb
    begin
        d5_prod    = 17'(rc_reg) * 17'(D5B_MAGIC);
        d5         = {1'b0, d5_prod[16:11]};
        dd3_next   = (neg3_reg[9] ? 7'd0 - d5 : d5) + 7'd1;
        ypart_next = {{8{yr_reg[9][19]}}, yr_reg[9]} * 28'd10000
                   + {{23{month_reg[4]}}, month_reg} * 28'(DIV_100);
    end

    // Output: pick the direction
    assign conv_next = mode_reg[10] ? ypart_reg + {{21{dd3_reg[6]}}, dd3_reg}
                                    : res_reg[10];

    // ------------------------------------------------------------------
    // Payload registers: advance with the stage, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            mode_reg[0] <= s_tuser;
            value_reg   <= s_tdata[VALUE_W-1:0];
        end
        if (stage_ready[1])
        begin
            mode_reg[1] <= mode_reg[0];
            rel_reg[1]  <= rel_next;
            rsum_reg[1] <= rsum_next;
            pack_reg    <= value_reg[26:0];
            q1_reg[1]   <= q1_prod[54:34];
            neg_reg[1]  <= t_full[30];
            abs_reg[1]  <= abs_next;
        end
        if (stage_ready[2])
        begin
            mode_reg[2] <= mode_reg[1];
            rel_reg[2]  <= rel_reg[1];
            rsum_reg[2] <= rsum_reg[1];
            q1_reg[2]   <= q1_reg[1];
            day_reg[2]  <= day_full[6:0];
            yq_reg      <= yq_prod[41:28];
            neg_reg[2]  <= neg_reg[1];
            abs_reg[2]  <= abs_reg[1];
            qa_reg[2]   <= qa_prod[59:48];
        end
        if (stage_ready[3])
        begin
            mode_reg[3]   <= mode_reg[2];
            rel_reg[3]    <= rel_reg[2];
            rsum_reg[3]   <= rsum_reg[2];
            day_reg[3]    <= day_reg[2];
            mshift_reg    <= mshift_next;
            yshift_reg[3] <= yshift_next;
            neg_reg[3]    <= neg_reg[2];
            qa_reg[3]     <= qa_reg[2];
            dd_reg        <= dd_next;
        end
        if (stage_ready[4])
        begin
            mode_reg[4]   <= mode_reg[3];
            rel_reg[4]    <= rel_reg[3];
            rsum_reg[4]   <= rsum_reg[3];
            day_reg[4]    <= day_reg[3];
            yshift_reg[4] <= yshift_reg[3];
            cen_reg       <= cen_prod[28:21];
            m153_reg      <= m153_next;
            neg_reg[4]    <= neg_reg[3];
            qa_reg[4]     <= qa_reg[3];
            neg2_reg[4]   <= dd_reg[16];
            abs2_reg[4]   <= abs2_next;
        end
        if (stage_ready[5])
        begin
            mode_reg[5] <= mode_reg[4];
            rel_reg[5]  <= rel_reg[4];
            rsum_reg[5] <= rsum_reg[4];
            day_reg[5]  <= day_reg[4];
            ry_reg      <= ry_full[6:0];
            t1_reg[5]   <= t1_prod[24:2];
            t3_reg[5]   <= t3_prod[28:17];
            neg2_reg[5] <= neg2_reg[4];
            abs2_reg[5] <= abs2_reg[4];
            qb_reg      <= qb_prod[35:29];
            yrc_reg     <= yrc_next;
        end
        if (stage_ready[6])
        begin
            mode_reg[6] <= mode_reg[5];
            rel_reg[6]  <= rel_reg[5];
            rsum_reg[6] <= rsum_reg[5];
            day_reg[6]  <= day_reg[5];
            t1_reg[6]   <= t1_reg[5];
            t3_reg[6]   <= t3_reg[5];
            t2_reg      <= t2_prod[17:2];
            dd2_reg     <= dd2_next;
            yr_reg[6]   <= yr6_next;
        end
        if (stage_ready[7])
        begin
            mode_reg[7] <= mode_reg[6];
            res_reg[7]  <= res_next;
            yr_reg[7]   <= yr_reg[6];
            neg3_reg[7] <= t3s[11];
            abs3_reg[7] <= abs3_next;
        end
        if (stage_ready[8])
        begin
            mode_reg[8] <= mode_reg[7];
            res_reg[8]  <= res_reg[7];
            yr_reg[8]   <= yr_reg[7];
            neg3_reg[8] <= neg3_reg[7];
            abs3_reg[8] <= abs3_reg[7];
            qc_reg      <= qc_prod[22:19];
        end
        if (stage_ready[9])
        begin
            mode_reg[9] <= mode_reg[8];
            res_reg[9]  <= res_reg[8];
            yr_reg[9]   <= yr9_next;
            neg3_reg[9] <= neg3_reg[8];
            rc_reg      <= rc_full[7:0];
            month_reg   <= month_next;
        end
        if (stage_ready[10])
        begin
            mode_reg[10] <= mode_reg[9];
            res_reg[10]  <= res_reg[9];
            dd3_reg      <= dd3_next;
            ypart_reg    <= ypart_next;
        end
        if (stage_ready[NUM_STAGES])
        begin
            out_data_reg <= conv_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Pipe occupancy moves only by accepted and delivered transactions.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> !$past(rst_n)
              || ($countones({valid_reg, out_valid_reg})
                  == $past($countones({valid_reg, out_valid_reg}))
                     + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy does not match accepted/delivered count");

    // Reciprocal quotient for the 400-year era never overshoots or undershoots.
    a_era_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (rem400 < 30'(DIV_400Y)))
        else $error("era remainder out of range");

    // Same for the 4-year cycle quotient.
    a_cycle_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (rem4y < 18'(DIV_4Y)))
        else $error("four-year remainder out of range");

endmodule
